>>> hdl/ezr_pkg.sv
// Shared constants, types and functions for the ZYX Euler angle to rotation matrix block.
package ezr_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int FRACTION_BITS = 16;
  localparam int OUT_W         = FRACTION_BITS + 2;
  localparam int CORDIC_STEPS  = 30;
  // Datapath width inside the CORDIC: values sit near 2^30 and the residual
  // angle reaches 2^30 in magnitude, so leave headroom.
  localparam int CW            = 34;
  // Width of the sine and cosine handed to the multipliers.
  localparam int SCW           = 32;
  localparam int PW            = 2 * SCW;
  localparam int TW            = PW + 2;
  localparam logic signed [CW-1:0] GAIN_INIT = CW'(652032874);

  typedef logic signed [CW-1:0]    cval_t;
  typedef logic signed [SCW-1:0]   sval_t;
  typedef logic signed [OUT_W-1:0] mval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
    logic  flip;
  } lane_t;

  typedef struct packed {
    sval_t s;
    sval_t c;
  } sc_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic cval_t atan_turn(input int i);
    cval_t r;
    unique case (i)
      0:  r = CW'(536870912);
      1:  r = CW'(316933406);
      2:  r = CW'(167458907);
      3:  r = CW'(85004756);
      4:  r = CW'(42667331);
      5:  r = CW'(21354465);
      6:  r = CW'(10679838);
      7:  r = CW'(5340245);
      8:  r = CW'(2670163);
      9:  r = CW'(1335087);
      10: r = CW'(667544);
      11: r = CW'(333772);
      12: r = CW'(166886);
      13: r = CW'(83443);
      14: r = CW'(41722);
      15: r = CW'(20861);
      16: r = CW'(10430);
      17: r = CW'(5215);
      18: r = CW'(2608);
      19: r = CW'(1304);
      20: r = CW'(652);
      21: r = CW'(326);
      22: r = CW'(163);
      23: r = CW'(81);
      24: r = CW'(41);
      25: r = CW'(20);
      26: r = CW'(10);
      27: r = CW'(5);
      28: r = CW'(3);
      29: r = CW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/ezr_if.sv
// Channel interfaces for the angle input and the matrix result.
interface ezr_in_if import ezr_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [ANGLE_BITS-1:0] yaw_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;

  modport source(output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink(input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface ezr_out_if import ezr_pkg::*; ();
  logic  valid;
  logic  ready;
  mval_t m_row1_col1;
  mval_t m_row1_col2;
  mval_t m_row1_col3;
  mval_t m_row2_col1;
  mval_t m_row2_col2;
  mval_t m_row2_col3;
  mval_t m_row3_col1;
  mval_t m_row3_col2;
  mval_t m_row3_col3;

  modport source(output valid, m_row1_col1, m_row1_col2, m_row1_col3,
                 m_row2_col1, m_row2_col2, m_row2_col3,
                 m_row3_col1, m_row3_col2, m_row3_col3, input ready);
  modport sink(input valid, m_row1_col1, m_row1_col2, m_row1_col3,
               m_row2_col1, m_row2_col2, m_row2_col3,
               m_row3_col1, m_row3_col2, m_row3_col3, output ready);
endinterface

>>> hdl/ezr_cordic.sv
// Pipelined three-lane CORDIC: sine and cosine of yaw, pitch and roll.
module ezr_cordic import ezr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [ANGLE_BITS-1:0] angle [3],
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output sc_t                          sc [3]
);

  localparam int NST = CORDIC_STEPS + 1;

  lane_t st_r [CORDIC_STEPS][3];
  sc_t   sc_r [3];
  logic  v_r  [NST];
  logic  en   [NST+1];
  lane_t init [3];

  function automatic lane_t cstep(input lane_t l, input int k);
    lane_t o;
    cval_t dx;
    cval_t dy;
    dx = l.y >>> k;
    dy = l.x >>> k;
    o  = l;
    if (!l.z[CW-1]) begin
      o.x = l.x - dx;
      o.y = l.y + dy;
      o.z = l.z - atan_turn(k);
    end else begin
      o.x = l.x + dx;
      o.y = l.y - dy;
      o.z = l.z + atan_turn(k);
    end
    return o;
  endfunction

  // Fold the angle into the right half plane; remember to negate at the end.
  always_comb begin
    logic [31:0] a;
    for (int i = 0; i < 3; i++) begin
      a = 32'(unsigned'(angle[i])) << (32 - ANGLE_BITS);
      init[i].flip = a[31] ^ a[30];
      if (init[i].flip) begin
        a[31] = ~a[31];
      end
      init[i].z = CW'(signed'(a));
      init[i].x = GAIN_INIT;
      init[i].y = '0;
    end
  end

  always_comb begin
    en[NST] = dn_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];
  assign sc       = sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  generate
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      always_ff @(posedge clk) begin
        if (en[k]) begin
          for (int i = 0; i < 3; i++) begin
            if (k == 0) begin
              st_r[k][i] <= cstep(init[i], k);
            end else begin
              st_r[k][i] <= cstep(st_r[(k == 0) ? 0 : k-1][i], k);
            end
          end
        end
      end
    end
  endgenerate

  // Undo the fold and narrow to the multiplier width.
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      for (int i = 0; i < 3; i++) begin
        if (st_r[CORDIC_STEPS-1][i].flip) begin
          sc_r[i].s <= SCW'(-st_r[CORDIC_STEPS-1][i].y);
          sc_r[i].c <= SCW'(-st_r[CORDIC_STEPS-1][i].x);
        end else begin
          sc_r[i].s <= SCW'(st_r[CORDIC_STEPS-1][i].y);
          sc_r[i].c <= SCW'(st_r[CORDIC_STEPS-1][i].x);
        end
      end
    end
  end

endmodule

>>> hdl/ezr_mat.sv
// Pipelined products, sums, rounding and saturation for the nine entries.
module ezr_mat import ezr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  sc_t   sc [3],
  output logic  dn_valid,
  input  logic  dn_ready,
  output mval_t m [9]
);

  localparam int NST = 5;
  localparam int SH  = 60 - FRACTION_BITS;
  localparam int SPW = PW - 30 + 1;

  logic v_r [NST];
  logic en  [NST+1];

  // Carried products: cycp, sycp, cpsr, cpcr, sycr, sysr, cycr, cysr, -sp.
  logic signed [PW-1:0]  c1_r [9];
  logic signed [PW-1:0]  c2_r [9];
  logic signed [PW-1:0]  c3_r [9];
  logic signed [PW-1:0]  spsr1_r, spcr1_r;
  logic signed [SPW-1:0] spsr2_r, spcr2_r;
  sval_t                 cy1_r, sy1_r, cy2_r, sy2_r;
  logic signed [TW-1:0]  t3_r [4];
  logic signed [TW-1:0]  e4_r [9];
  mval_t                 m_r  [9];

  function automatic mval_t finish(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] t;
    logic signed [TW-1:0] one;
    t   = (v + (TW'(1) <<< (SH - 1))) >>> SH;
    one = TW'(1) <<< FRACTION_BITS;
    if (t > one) begin
      t = one;
    end else if (t < -one) begin
      t = -one;
    end
    return OUT_W'(t);
  endfunction

  always_comb begin
    en[NST] = dn_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];
  assign m        = m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // sc[0] = yaw, sc[1] = pitch, sc[2] = roll.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      spsr1_r <= sc[1].s * sc[2].s;
      spcr1_r <= sc[1].s * sc[2].c;
      c1_r[0] <= sc[0].c * sc[1].c;
      c1_r[1] <= sc[0].s * sc[1].c;
      c1_r[2] <= sc[1].c * sc[2].s;
      c1_r[3] <= sc[1].c * sc[2].c;
      c1_r[4] <= sc[0].s * sc[2].c;
      c1_r[5] <= sc[0].s * sc[2].s;
      c1_r[6] <= sc[0].c * sc[2].c;
      c1_r[7] <= sc[0].c * sc[2].s;
      c1_r[8] <= (-PW'(sc[1].s)) <<< 30;
      cy1_r   <= sc[0].c;
      sy1_r   <= sc[0].s;
    end
    if (en[1]) begin
      spsr2_r <= SPW'((spsr1_r + (PW'(1) <<< 29)) >>> 30);
      spcr2_r <= SPW'((spcr1_r + (PW'(1) <<< 29)) >>> 30);
      c2_r    <= c1_r;
      cy2_r   <= cy1_r;
      sy2_r   <= sy1_r;
    end
    if (en[2]) begin
      t3_r[0] <= TW'(cy2_r) * TW'(spsr2_r);
      t3_r[1] <= TW'(sy2_r) * TW'(spsr2_r);
      t3_r[2] <= TW'(cy2_r) * TW'(spcr2_r);
      t3_r[3] <= TW'(sy2_r) * TW'(spcr2_r);
      c3_r    <= c2_r;
    end
    if (en[3]) begin
      e4_r[0] <= TW'(c3_r[0]);
      e4_r[1] <= t3_r[0] - TW'(c3_r[4]);
      e4_r[2] <= t3_r[2] + TW'(c3_r[5]);
      e4_r[3] <= TW'(c3_r[1]);
      e4_r[4] <= t3_r[1] + TW'(c3_r[6]);
      e4_r[5] <= t3_r[3] - TW'(c3_r[7]);
      e4_r[6] <= TW'(c3_r[8]);
      e4_r[7] <= TW'(c3_r[2]);
      e4_r[8] <= TW'(c3_r[3]);
    end
    if (en[4]) begin
      for (int i = 0; i < 9; i++) begin
        m_r[i] <= finish(e4_r[i]);
      end
    end
  end

endmodule

>>> hdl/euler_zyx_to_rotation_matrix.sv
// Top level: ZYX Euler angles to 3x3 rotation matrix, fully pipelined.
//
// Usage:
//   in_ch carries one beat of yaw, pitch and roll (signed binary angles,
//   a full turn is 2^ANGLE_BITS). out_ch carries one beat of nine matrix
//   entries of R = Rz(yaw)*Ry(pitch)*Rx(roll), each signed with
//   FRACTION_BITS fraction bits, rounded half up and clamped to +/-1.0.
//   A beat moves on a rising edge with valid and ready both high.
// Pipeline: an accepted input beat passes through 31 CORDIC stages (one
//   micro-rotation per stage, then the quadrant fix) and 5 stages of
//   products, rounding, sums and clamping before its output beat is shown.
// Throughput: one beat per cycle while out_ch.ready stays high; each stage
//   holds one item and its own valid bit.
// Reset: rst_n low on a clock edge empties every stage; no other state.
// Stall: when out_ch.ready is low the output beat holds; earlier stages
//   keep advancing into empty slots, so in_ch.ready drops only once the
//   whole pipeline is full. Nothing is dropped or repeated.
module euler_zyx_to_rotation_matrix import ezr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  ezr_in_if.sink     in_ch,
  ezr_out_if.source  out_ch
);

  logic                         cor_valid;
  logic                         cor_ready;
  sc_t                          cor_sc [3];
  logic signed [ANGLE_BITS-1:0] angles [3];
  mval_t                        m [9];

  // Lane order: yaw, pitch, roll.
  assign angles[0] = in_ch.yaw_angle;
  assign angles[1] = in_ch.pitch_angle;
  assign angles[2] = in_ch.roll_angle;

  ezr_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .angle    (angles),
    .dn_valid (cor_valid),
    .dn_ready (cor_ready),
    .sc       (cor_sc)
  );

  ezr_mat u_mat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cor_valid),
    .up_ready (cor_ready),
    .sc       (cor_sc),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .m        (m)
  );

  assign out_ch.m_row1_col1 = m[0];
  assign out_ch.m_row1_col2 = m[1];
  assign out_ch.m_row1_col3 = m[2];
  assign out_ch.m_row2_col1 = m[3];
  assign out_ch.m_row2_col2 = m[4];
  assign out_ch.m_row2_col3 = m[5];
  assign out_ch.m_row3_col1 = m[6];
  assign out_ch.m_row3_col2 = m[7];
  assign out_ch.m_row3_col3 = m[8];

endmodule
